@@ hdl/byte_ring_buffer_unit_macros.svh @@
// Assertion macros used by the checker module of the byte ring buffer.
// Every macro is clocked on the rising edge and idles while reset is low.
`ifndef BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication.
`define BRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/brb_pkg.sv @@
// Package of the byte ring buffer: request and result types, function codes,
// controller states and the command/status groups. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    localparam int CNT_W = 7;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_DISCARD = 2'd1;
    localparam logic [1:0] FUNC_PEEK    = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic             first_of_run;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       data_out;
        logic [CNT_W-1:0] done_count;
        logic             accepted;
        logic             last;
        logic [CNT_W-1:0] fill_level;
        logic [CNT_W-1:0] free_space;
    } t_out_item;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_PEEK = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic peek_step;
    } t_brb_cmd;

    typedef struct packed {
        logic out_free;
        logic start_peek;
        logic peek_final;
    } t_brb_status;

endpackage

`default_nettype wire

@@ hdl/brb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/brb_ctrl.sv @@
// Controller of the byte ring buffer: idle/peek state machine.
// Depends on brb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl
    import brb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_brb_status i_status,
    output t_brb_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.peek_step = 1'b0;
        o_in_stall      = 1'b1;
        case (r_state)
            S_IDLE: begin
                // take a request only when the result register can take its answer
                o_in_stall   = !i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
                if (o_cmd.accept && i_status.start_peek) begin
                    n_state = S_PEEK;
                end
            end
            S_PEEK: begin
                o_cmd.peek_step = i_status.out_free;
                if (i_status.out_free && i_status.peek_final) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/brb_datapath.sv @@
// Datapath of the byte ring buffer: indexes, fill count, run state, peek
// counters, result register and the byte store. Depends on brb_pkg, brb_ram.
`timescale 1ns / 1ps
`default_nettype none

module brb_datapath
    import brb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_brb_cmd  i_cmd,
    output t_brb_status    o_status,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_item
);

    localparam int               IDX_W   = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_run_rem, n_run_rem;
    logic             r_run_acc, n_run_acc;
    logic [IDX_W-1:0] r_pk_idx, n_pk_idx;
    logic [CNT_W-1:0] r_pk_left, n_pk_left;
    logic [CNT_W-1:0] r_pk_n, n_pk_n;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [CNT_W-1:0] free;
    logic [CNT_W-1:0] take_n;
    logic [CNT_W-1:0] run_rem_eff;
    logic             run_acc_eff;
    logic             store;
    logic [CNT_W-1:0] head_sum;
    logic             load;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    assign free   = DEPTH_C - r_fill;
    assign take_n = (i_in_item.count < r_fill) ? i_in_item.count : r_fill;

    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.start_peek = (i_in_item.func == FUNC_PEEK) && (take_n != '0);
    assign o_status.peek_final = (r_pk_left == CNT_W'(1));

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_run_rem   = r_run_rem;
        n_run_acc   = r_run_acc;
        n_pk_idx    = r_pk_idx;
        n_pk_left   = r_pk_left;
        n_pk_n      = r_pk_n;
        n_out       = r_out;
        load        = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_pk_idx;
        run_rem_eff = r_run_rem;
        run_acc_eff = r_run_acc;
        store       = 1'b0;
        head_sum    = CNT_W'(r_head) + take_n;

        if (i_cmd.accept) begin
            case (i_in_item.func)
                FUNC_INSERT: begin
                    if (i_in_item.first_of_run) begin
                        run_rem_eff = i_in_item.count;
                        run_acc_eff = (i_in_item.count != '0) && (free > i_in_item.count);
                    end
                    store = (run_rem_eff != '0) && run_acc_eff && (r_fill < DEPTH_C);
                    n_run_rem = run_rem_eff;
                    n_run_acc = run_acc_eff;
                    if (run_rem_eff != '0) begin
                        n_run_rem = run_rem_eff - 1'b1;
                        if (run_rem_eff == CNT_W'(1)) begin
                            n_run_acc = 1'b0;
                        end
                    end
                    if (store) begin
                        wr_en  = 1'b1;
                        n_tail = f_next(r_tail);
                        n_fill = r_fill + 1'b1;
                    end
                    load             = 1'b1;
                    n_out            = '0;
                    n_out.done_count = CNT_W'(store);
                    n_out.accepted   = (run_rem_eff != '0) && run_acc_eff;
                    n_out.last       = 1'b1;
                    n_out.fill_level = n_fill;
                    n_out.free_space = DEPTH_C - n_fill;
                end
                FUNC_DISCARD: begin
                    if (head_sum >= DEPTH_C) begin
                        head_sum = head_sum - DEPTH_C;
                    end
                    n_head           = IDX_W'(head_sum);
                    n_fill           = r_fill - take_n;
                    load             = 1'b1;
                    n_out            = '0;
                    n_out.done_count = take_n;
                    n_out.last       = 1'b1;
                    n_out.fill_level = n_fill;
                    n_out.free_space = DEPTH_C - n_fill;
                end
                FUNC_PEEK: begin
                    if (take_n == '0) begin
                        load             = 1'b1;
                        n_out            = '0;
                        n_out.last       = 1'b1;
                        n_out.fill_level = r_fill;
                        n_out.free_space = free;
                    end else begin
                        // fetch the head byte now, stream the rest from the peek state
                        rd_en     = 1'b1;
                        rd_addr   = r_head;
                        n_pk_idx  = f_next(r_head);
                        n_pk_left = take_n;
                        n_pk_n    = take_n;
                    end
                end
                default: begin
                    load             = 1'b1;
                    n_out            = '0;
                    n_out.last       = 1'b1;
                    n_out.fill_level = r_fill;
                    n_out.free_space = free;
                end
            endcase
        end

        if (i_cmd.peek_step) begin
            load             = 1'b1;
            n_out.data_out   = rd_data;
            n_out.done_count = r_pk_n;
            n_out.accepted   = 1'b0;
            n_out.last       = o_status.peek_final;
            n_out.fill_level = r_fill;
            n_out.free_space = free;
            n_pk_left        = r_pk_left - 1'b1;
            if (!o_status.peek_final) begin
                rd_en    = 1'b1;
                rd_addr  = r_pk_idx;
                n_pk_idx = f_next(r_pk_idx);
            end
        end

        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_run_rem   <= '0;
            r_run_acc   <= 1'b0;
            r_pk_left   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_run_rem   <= n_run_rem;
            r_run_acc   <= n_run_acc;
            r_pk_left   <= n_pk_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pk_idx <= n_pk_idx;
        r_pk_n   <= n_pk_n;
        r_out    <= n_out;
    end

    brb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_tail),
        .i_wr_data(i_in_item.data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ hdl/byte_ring_buffer_unit.sv @@
// Byte ring buffer, top level: requests in, results out, valid/stall on both.
// Request channel: i_in_valid / o_in_stall / i_in_item; result channel:
// o_out_valid / i_out_stall / o_out_item. A transfer happens on a rising edge
// with valid high and stall low.
// Insert, discard and unknown-function requests give one result, registered
// in the cycle after acceptance; one request per cycle absent receiver stalls.
// A peek of n stored bytes gives n results, one per cycle absent receiver
// stalls, the first through the byte store's read register and then the
// result register; requests are stalled until the last byte is loaded.
// The rate is set by the single registered read port of the byte store.
// A receiver stall holds the result register; the block then stalls its
// request side for as long as the held result cannot move on.
// Reset (i_rst_n low, synchronous) empties the buffer and clears the run
// and handshake state; the byte store itself is not cleared, since only
// written entries are ever read.
// Depends on brb_pkg, brb_ctrl, brb_datapath, brb_ram.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_unit
    import brb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    // command and status between the state machine and the datapath
    t_brb_cmd    cmd;
    t_brb_status status;

    // sequence requests: accept in idle, step through peek bytes otherwise
    brb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // hold indexes, fill and run state; drive the byte store and result register
    brb_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_item  (i_in_item),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

@@ hdl/brb_checker.sv @@
// Port-level checker of the byte ring buffer, bound to the top level.
// Depends on brb_pkg and byte_ring_buffer_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_ring_buffer_unit_macros.svh"

module brb_checker
    import brb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    logic [CNT_W:0] level_sum;
    logic           in_take;

    assign level_sum = (CNT_W+1)'(o_out_item.fill_level) + (CNT_W+1)'(o_out_item.free_space);
    assign in_take   = i_in_valid && !o_in_stall && (i_in_item.func != FUNC_PEEK);

    // a stalled result holds
    `BRB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "result changed under stall")

    // fill and free space always add up to the depth
    `BRB_ASSERT_IMP(a_level_sum, i_clk, i_rst_n, o_out_valid, level_sum == (CNT_W+1)'(DEPTH), "fill plus free differs from depth")

    // the buffer never fills completely
    `BRB_ASSERT_IMP(a_never_full, i_clk, i_rst_n, o_out_valid, o_out_item.free_space != '0, "buffer reported full")

    // while a peek is still streaming, no new request is taken
    `BRB_ASSERT_IMP(a_peek_blocks, i_clk, i_rst_n, o_out_valid && !o_out_item.last, o_in_stall, "request taken during peek")

    // a non-peek request shows up as a final result in the next cycle
    `BRB_ASSERT_NXT(a_single_result, i_clk, i_rst_n, in_take, o_out_valid && o_out_item.last, "single result missing")

endmodule

bind byte_ring_buffer_unit brb_checker #(.DEPTH(DEPTH)) u_brb_checker (.*);

`default_nettype wire

@@ dv/byte_ring_buffer_unit_checker.sv @@
// Checker for the byte ring buffer: watches both valid/stall channels, predicts the
// results of every accepted request and compares them with what the block returns.
// Depends on brb_pkg for the request and result types and the function codes.
`timescale 1ns / 1ps

module byte_ring_buffer_unit_checker
    import brb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int MAX_REPORTS = 10;

    // Shadow copy of the buffer contents and pointers.
    logic [7:0]       ring_bytes [DEPTH];
    int unsigned      rd_pos;
    int unsigned      wr_pos;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] run_left;
    logic             run_on;

    t_out_item awaited_results [$];
    int        mismatches = 0;

    // Build one result; fill and free space reflect the state after the step.
    function automatic t_out_item make_result(input logic [7:0] byte_val,
                                              input logic [CNT_W-1:0] done,
                                              input logic acc,
                                              input logic fin);
        t_out_item r;
        r.data_out   = byte_val;
        r.done_count = done;
        r.accepted   = acc;
        r.last       = fin;
        r.fill_level = fill;
        r.free_space = CNT_W'(DEPTH - fill);
        return r;
    endfunction

    task automatic predict_request(input t_in_item req);
        logic [CNT_W-1:0] n;
        logic             stored;
        logic             acc;
        int unsigned      pos;
        stored = 1'b0;
        case (req.func)
            FUNC_INSERT: begin
                if (req.first_of_run) begin
                    run_left = req.count;
                    run_on   = (req.count != 0) && ((DEPTH - fill) > req.count);
                end
                acc = (run_left != 0) ? run_on : 1'b0;
                if (run_left != 0) begin
                    if (run_on && fill < DEPTH) begin
                        ring_bytes[wr_pos] = req.data;
                        wr_pos = (wr_pos + 1) % DEPTH;
                        fill   = fill + 1'b1;
                        stored = 1'b1;
                    end
                    run_left = run_left - 1'b1;
                    if (run_left == 0) begin
                        run_on = 1'b0;
                    end
                end
                awaited_results.push_back(make_result(8'd0, CNT_W'(stored), acc, 1'b1));
            end
            FUNC_DISCARD: begin
                n      = (req.count < fill) ? req.count : fill;
                rd_pos = (rd_pos + n) % DEPTH;
                fill   = fill - n;
                awaited_results.push_back(make_result(8'd0, n, 1'b0, 1'b1));
            end
            FUNC_PEEK: begin
                n = (req.count < fill) ? req.count : fill;
                if (n == 0) begin
                    awaited_results.push_back(make_result(8'd0, '0, 1'b0, 1'b1));
                end else begin
                    pos = rd_pos;
                    for (int k = 0; k < n; k++) begin
                        awaited_results.push_back(
                            make_result(ring_bytes[pos], n, 1'b0, (k + 1 == n)));
                        pos = (pos + 1) % DEPTH;
                    end
                end
            end
            default: begin
                awaited_results.push_back(make_result(8'd0, '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: result with nothing outstanding: data %02h done %0d acc %b",
                         $time, got.data_out, got.done_count, got.accepted,
                         " last %b fill %0d free %0d", got.last, got.fill_level,
                         got.free_space);
            end
        end else begin
            want = awaited_results.pop_front();
            if (got.data_out !== want.data_out || got.done_count !== want.done_count ||
                got.accepted !== want.accepted || got.last !== want.last ||
                got.fill_level !== want.fill_level ||
                got.free_space !== want.free_space) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected data %02h done %0d acc %b last %b fill %0d free %0d",
                             want.data_out, want.done_count, want.accepted, want.last,
                             want.fill_level, want.free_space);
                    $display("  actual   data %02h done %0d acc %b last %b fill %0d free %0d",
                             got.data_out, got.done_count, got.accepted, got.last,
                             got.fill_level, got.free_space);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_pos   = 0;
            wr_pos   = 0;
            fill     = '0;
            run_left = '0;
            run_on   = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_item);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_in_item);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ dv/byte_ring_buffer_unit_test.sv @@
// Top of the byte ring buffer testbench: clock, reset, request stimulus, result-side
// stalls, a no-progress watchdog and the final verdict.
// Depends on brb_pkg, byte_ring_buffer_unit and byte_ring_buffer_unit_checker.
`timescale 1ns / 1ps

module byte_ring_buffer_unit_test;
    import brb_pkg::*;

    localparam int DEPTH        = 64;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int REQ_TARGET   = 460;
    // Even a long peek under heavy receiver stalls keeps moving results, so
    // this many cycles without any transfer means a hang.
    localparam int QUIET_LIMIT  = 2000;
    // Peek results pass the read and result registers; leave margin for strays.
    localparam int DRAIN_CYCLES = 16;

    // Function code the block does not implement; it must be ignored.
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count;
    int pending;
    int quiet_cycles   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    byte_ring_buffer_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    byte_ring_buffer_unit_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver: stall the result channel at random, cycle by cycle.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Watchdog: end the run once nothing has moved on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request, with a random idle gap ahead of it, and hold it until
    // the block takes it. Return at the edge of acceptance.
    task automatic send_request(input logic [1:0] func, input logic [7:0] data,
                                input logic [CNT_W-1:0] count, input logic first_flag);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item  <= '{func: func, data: data, count: count, first_of_run: first_flag};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Send a peek or a discard; mostly short spans, some at or beyond the depth.
    task automatic send_head_op();
        logic [1:0] op;
        int         span;
        op = $urandom_range(1, 0) ? FUNC_PEEK : FUNC_DISCARD;
        case ($urandom_range(9, 0))
            0:       span = $urandom_range(127, 64);
            1, 2:    span = $urandom_range(63, 17);
            default: span = $urandom_range(16, 0);
        endcase
        send_request(op, 8'($urandom_range(255, 0)), CNT_W'(span),
                     1'($urandom_range(1, 0)));
    endtask

    // Mostly well-formed insert runs with random bytes, mixed with peeks and
    // discards; some runs are abandoned early, oversize or empty, and a few
    // stray bytes and unknown functions act as noise.
    task automatic random_traffic(input int goal);
        int sent;
        int pick;
        int run_len;
        int run_bytes;
        sent = 0;
        while (sent < goal) begin
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                case ($urandom_range(19, 0))
                    0:       run_len = 0;
                    1:       run_len = $urandom_range(127, 64);
                    2, 3:    run_len = $urandom_range(63, 40);
                    default: run_len = $urandom_range(12, 1);
                endcase
                // Oversize runs are abandoned after a few bytes to keep the run short.
                if (run_len == 0) begin
                    run_bytes = 1;
                end else if (run_len >= DEPTH) begin
                    run_bytes = $urandom_range(6, 1);
                end else if ($urandom_range(9, 0) == 0) begin
                    run_bytes = $urandom_range(run_len, 1);
                end else begin
                    run_bytes = run_len;
                end
                send_request(FUNC_INSERT, 8'($urandom_range(255, 0)), CNT_W'(run_len),
                             1'b1);
                sent++;
                for (int k = 1; k < run_bytes; k++) begin
                    if ($urandom_range(11, 0) == 0) begin
                        send_head_op();
                        sent++;
                    end
                    send_request(FUNC_INSERT, 8'($urandom_range(255, 0)),
                                 CNT_W'($urandom_range(127, 0)), 1'b0);
                    sent++;
                end
                // At times trail one more byte; a run cut short still counts it in.
                if ($urandom_range(19, 0) == 0) begin
                    send_request(FUNC_INSERT, 8'($urandom_range(255, 0)),
                                 CNT_W'($urandom_range(127, 0)), 1'b0);
                end
            end else if (pick < 95) begin
                send_head_op();
                sent++;
            end else begin
                send_request(FUNC_RESERVED, 8'($urandom_range(255, 0)),
                             CNT_W'($urandom_range(127, 0)), 1'($urandom_range(1, 0)));
            end
        end
    endtask

    initial begin
        send_idle_pct  <= 19;
        recv_stall_pct <= 76;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty buffer, ignored requests, run corner cases.
        send_request(FUNC_PEEK,     8'h00, 7'd5,   1'b0); // peek on empty buffer
        send_request(FUNC_DISCARD,  8'h00, 7'd127, 1'b0); // discard clamps to zero
        send_request(FUNC_RESERVED, 8'hFF, 7'd127, 1'b1); // unknown function
        send_request(FUNC_INSERT,   8'h3C, 7'd9,   1'b0); // byte outside any run
        send_request(FUNC_INSERT,   8'hFF, 7'd0,   1'b1); // zero-length run
        send_request(FUNC_INSERT,   8'h00, 7'd127, 1'b1); // oversize run, rejected
        send_request(FUNC_INSERT,   8'h11, 7'd0,   1'b0); // consumed, not stored
        send_request(FUNC_INSERT,   8'h00, 7'd3,   1'b1); // new run abandons old one
        send_request(FUNC_INSERT,   8'hFF, 7'd0,   1'b0);
        send_request(FUNC_PEEK,     8'h00, 7'd127, 1'b0); // peek inside a run
        send_request(FUNC_DISCARD,  8'h00, 7'd0,   1'b0); // zero discard inside a run
        send_request(FUNC_INSERT,   8'hA5, 7'd0,   1'b0); // completes the run
        send_request(FUNC_INSERT,   8'h5A, 7'd0,   1'b0); // past the end, ignored
        send_request(FUNC_PEEK,     8'h00, 7'd0,   1'b0); // zero peek
        send_request(FUNC_PEEK,     8'h00, 7'd2,   1'b0);
        send_request(FUNC_DISCARD,  8'h00, 7'd1,   1'b0);
        // Two bytes stored, 62 free: a 62-byte run must not fit, 61 must.
        send_request(FUNC_INSERT,   8'h80, 7'd62,  1'b1);
        send_request(FUNC_INSERT,   8'h01, 7'd61,  1'b1);
        send_request(FUNC_INSERT,   8'h7F, 7'd1,   1'b1);
        send_request(FUNC_PEEK,     8'h00, 7'd64,  1'b1);
        send_request(FUNC_DISCARD,  8'hFF, 7'd64,  1'b1);
        send_request(FUNC_PEEK,     8'h00, 7'd1,   1'b0);

        // Random: sender lightly idle, receiver heavily stalled, then swapped,
        // then both at full rate.
        random_traffic(REQ_TARGET / 3);
        send_idle_pct  <= 76;
        recv_stall_pct <= 19;
        random_traffic(REQ_TARGET / 3);
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        random_traffic(REQ_TARGET - 2 * (REQ_TARGET / 3));

        // Drain: the pending count is registered behind the checker, so let an edge
        // pass before polling it, then leave room for any stray result.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/brb_pkg.sv
hdl/brb_ram.sv
hdl/brb_ctrl.sv
hdl/brb_datapath.sv
hdl/byte_ring_buffer_unit.sv
hdl/brb_checker.sv
dv/byte_ring_buffer_unit_checker.sv
dv/byte_ring_buffer_unit_test.sv
